[src/utf8_encoder_with_color_escapes_defines.svh]
// Assertion macros for the UTF-8 terminal encoder.
// Each macro samples on the rising edge of i_clk of the module that uses it.
`ifndef UTF8_ENCODER_WITH_COLOR_ESCAPES_DEFINES_SVH
`define UTF8_ENCODER_WITH_COLOR_ESCAPES_DEFINES_SVH

// Same-cycle implication, off while reset is held.
`define UE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, off while reset is held.
`define UE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

// Next-cycle implication that also runs through reset.
`define UE_ASSERT_ALWAYS_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) (ante) |=> (cons)) else $error(msg);

`endif

[src/ue_pkg.sv]
`timescale 1ns / 1ps
package ue_pkg;

    localparam logic [7:0]  ESC_BYTE     = 8'h1B;
    localparam logic [7:0]  LBRACK_BYTE  = 8'h5B;
    localparam logic [7:0]  M_BYTE       = 8'h6D;
    localparam logic [7:0]  DIGIT0_BYTE  = 8'h30;
    localparam logic [20:0] CP_MAX       = 21'h10FFFF;
    localparam logic [20:0] CP_1B_MAX    = 21'h00007F;
    localparam logic [20:0] CP_2B_LIMIT  = 21'h000800;
    localparam logic [20:0] CP_3B_LIMIT  = 21'h010000;
    localparam logic [7:0]  LEAD2        = 8'hC0;
    localparam logic [7:0]  LEAD3        = 8'hE0;
    localparam logic [7:0]  LEAD4        = 8'hF0;
    localparam logic [7:0]  CONT         = 8'h80;

    localparam logic [6:0]  FORE_OFFSET_RESET = 7'd30;
    localparam logic [6:0]  BACK_OFFSET_RESET = 7'd40;
    localparam logic [7:0]  COLOUR_RESET      = 8'd255;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic {
        CFG_FORE_OFFSET = 1'b0,
        CFG_BACK_OFFSET = 1'b1
    } t_cfg_reg;

    typedef enum logic [1:0] {
        SEG_FORE = 2'd0,
        SEG_BACK = 2'd1,
        SEG_UTF  = 2'd2
    } t_seg_sel;

    // One run of bytes, left packed; len 0 means the run is absent.
    typedef struct packed {
        logic [5:0][7:0] bytes;
        logic [2:0]      len;
    } t_seg;

    // Everything the serializer needs for one item.
    typedef struct packed {
        t_seg fore;
        t_seg back;
        t_seg utf;
    } t_job;

endpackage

[src/ue_front.sv]
`timescale 1ns / 1ps
module ue_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_accept,
    input  logic [7:0]     i_fore_colour,
    input  logic [7:0]     i_back_colour,
    input  logic [20:0]    i_code_point,
    input  logic [6:0]     i_fore_offset,
    input  logic [6:0]     i_back_offset,
    output ue_pkg::t_job   o_job
);

    // Build ESC [ <decimal> m for a number in 0..382.
    function automatic ue_pkg::t_seg build_escape(input logic [8:0] num);
        ue_pkg::t_seg seg;
        logic [3:0]   hund;
        logic [8:0]   rem9;
        logic [6:0]   rem;
        logic [3:0]   tens;
        logic [3:0]   ones;
        hund = 4'd0;
        rem9 = num;
        if (num >= 9'd300) begin
            hund = 4'd3;
            rem9 = num - 9'd300;
        end else if (num >= 9'd200) begin
            hund = 4'd2;
            rem9 = num - 9'd200;
        end else if (num >= 9'd100) begin
            hund = 4'd1;
            rem9 = num - 9'd100;
        end
        rem  = rem9[6:0];
        tens = 4'd0;
        for (int j = 1; j <= 9; j++) begin
            if (rem >= 7'(j * 10)) begin
                tens = 4'(j);
            end
        end
        ones = 4'(rem - 7'(7'({3'd0, tens}) * 7'd10));
        seg = '0;
        seg.bytes[0] = ue_pkg::ESC_BYTE;
        seg.bytes[1] = ue_pkg::LBRACK_BYTE;
        if (hund != 4'd0) begin
            seg.bytes[2] = ue_pkg::DIGIT0_BYTE + {4'd0, hund};
            seg.bytes[3] = ue_pkg::DIGIT0_BYTE + {4'd0, tens};
            seg.bytes[4] = ue_pkg::DIGIT0_BYTE + {4'd0, ones};
            seg.bytes[5] = ue_pkg::M_BYTE;
            seg.len      = 3'd6;
        end else if (tens != 4'd0) begin
            seg.bytes[2] = ue_pkg::DIGIT0_BYTE + {4'd0, tens};
            seg.bytes[3] = ue_pkg::DIGIT0_BYTE + {4'd0, ones};
            seg.bytes[4] = ue_pkg::M_BYTE;
            seg.len      = 3'd5;
        end else begin
            seg.bytes[2] = ue_pkg::DIGIT0_BYTE + {4'd0, ones};
            seg.bytes[3] = ue_pkg::M_BYTE;
            seg.len      = 3'd4;
        end
        return seg;
    endfunction

    logic [7:0]  r_cur_fore;
    logic [7:0]  r_cur_back;
    logic [20:0] cp;
    logic [8:0]  fore_num;
    logic [8:0]  back_num;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_fore <= ue_pkg::COLOUR_RESET;
            r_cur_back <= ue_pkg::COLOUR_RESET;
        end else if (i_accept) begin
            r_cur_fore <= i_fore_colour;
            r_cur_back <= i_back_colour;
        end
    end

    always_comb begin
        fore_num = {2'd0, i_fore_offset} + {1'b0, i_fore_colour};
        back_num = {2'd0, i_back_offset} + {1'b0, i_back_colour};
        cp = (i_code_point > ue_pkg::CP_MAX) ? ue_pkg::CP_MAX : i_code_point;

        o_job = '0;
        if (i_fore_colour != r_cur_fore) begin
            o_job.fore = build_escape(fore_num);
        end
        if (i_back_colour != r_cur_back) begin
            o_job.back = build_escape(back_num);
        end

        if (cp <= ue_pkg::CP_1B_MAX) begin
            o_job.utf.bytes[0] = cp[7:0];
            o_job.utf.len      = 3'd1;
        end else if (cp < ue_pkg::CP_2B_LIMIT) begin
            o_job.utf.bytes[0] = ue_pkg::LEAD2 | {3'd0, cp[10:6]};
            o_job.utf.bytes[1] = ue_pkg::CONT | {2'd0, cp[5:0]};
            o_job.utf.len      = 3'd2;
        end else if (cp < ue_pkg::CP_3B_LIMIT) begin
            o_job.utf.bytes[0] = ue_pkg::LEAD3 | {4'd0, cp[15:12]};
            o_job.utf.bytes[1] = ue_pkg::CONT | {2'd0, cp[11:6]};
            o_job.utf.bytes[2] = ue_pkg::CONT | {2'd0, cp[5:0]};
            o_job.utf.len      = 3'd3;
        end else begin
            o_job.utf.bytes[0] = ue_pkg::LEAD4 | {5'd0, cp[20:18]};
            o_job.utf.bytes[1] = ue_pkg::CONT | {2'd0, cp[17:12]};
            o_job.utf.bytes[2] = ue_pkg::CONT | {2'd0, cp[11:6]};
            o_job.utf.bytes[3] = ue_pkg::CONT | {2'd0, cp[5:0]};
            o_job.utf.len      = 3'd4;
        end
    end

endmodule

[src/ue_queue.sv]
`timescale 1ns / 1ps
module ue_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  ue_pkg::t_job  i_job,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output ue_pkg::t_job  o_job
);

    ue_pkg::t_job                   r_mem [ue_pkg::QUEUE_DEPTH];
    logic [ue_pkg::QUEUE_PTR_W-1:0] r_wr_ptr;
    logic [ue_pkg::QUEUE_PTR_W-1:0] r_rd_ptr;
    logic [ue_pkg::QUEUE_CNT_W-1:0] r_count;
    logic                           do_push;
    logic                           do_pop;

    assign o_full  = (r_count == ue_pkg::QUEUE_CNT_W'(ue_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

[src/ue_back.sv]
`timescale 1ns / 1ps
module ue_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  ue_pkg::t_job  i_job,
    input  logic          i_job_valid,
    output logic          o_job_pop,
    input  logic          i_pop,
    output logic          o_empty,
    output logic [7:0]    o_out_byte,
    output logic          o_last_byte
);

    logic             r_first;
    ue_pkg::t_seg_sel r_seg;
    logic [2:0]       r_idx;
    logic             r_out_valid;
    logic [7:0]       r_out_byte;
    logic             r_out_last;

    ue_pkg::t_seg_sel first_seg;
    ue_pkg::t_seg_sel eff_seg;
    ue_pkg::t_seg_sel after_seg;
    logic [2:0]       eff_idx;
    ue_pkg::t_seg     cur;
    logic             seg_end;
    logic             item_end;
    logic             out_ready;
    logic             fire;

    always_comb begin
        if (i_job.fore.len != 3'd0) begin
            first_seg = ue_pkg::SEG_FORE;
        end else if (i_job.back.len != 3'd0) begin
            first_seg = ue_pkg::SEG_BACK;
        end else begin
            first_seg = ue_pkg::SEG_UTF;
        end
        eff_seg = r_first ? first_seg : r_seg;
        eff_idx = r_first ? 3'd0 : r_idx;
        case (eff_seg)
            ue_pkg::SEG_FORE: cur = i_job.fore;
            ue_pkg::SEG_BACK: cur = i_job.back;
            default:          cur = i_job.utf;
        endcase
        seg_end  = (eff_idx == cur.len - 3'd1);
        item_end = seg_end && (eff_seg == ue_pkg::SEG_UTF);
        if (eff_seg == ue_pkg::SEG_FORE && i_job.back.len != 3'd0) begin
            after_seg = ue_pkg::SEG_BACK;
        end else begin
            after_seg = ue_pkg::SEG_UTF;
        end
        out_ready = !r_out_valid || i_pop;
        fire      = i_job_valid && out_ready;
        o_job_pop = fire && item_end;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first     <= 1'b1;
            r_seg       <= ue_pkg::SEG_FORE;
            r_idx       <= 3'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (fire) begin
                if (item_end) begin
                    r_first <= 1'b1;
                end else if (seg_end) begin
                    r_first <= 1'b0;
                    r_seg   <= after_seg;
                    r_idx   <= 3'd0;
                end else begin
                    r_first <= 1'b0;
                    r_seg   <= eff_seg;
                    r_idx   <= eff_idx + 3'd1;
                end
            end
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_byte <= cur.bytes[eff_idx];
            r_out_last <= item_end;
        end
    end

    assign o_empty     = !r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_last_byte = r_out_last;

endmodule

[src/utf8_encoder_with_color_escapes.sv]
`timescale 1ns / 1ps
// Terminal byte encoder: each item is one character cell (foreground colour,
// background colour, code point) and comes out as a byte stream, one byte
// per result, with o_last_byte high on the cell's final byte. A colour that
// differs from the one last sent is preceded by ESC [ <offset+colour> m, the
// number in decimal without leading zeros; both kept colours start at 255,
// so a first cell in colour 255 sends no escape. Code points above 0x10FFFF
// are clamped to 0x10FFFF; surrogates encode as plain three-byte sequences.
// Throughput: an item has 1 to 16 bytes (one to four UTF-8 bytes, plus
// four to six per colour escape), sent by the one-byte-per-cycle serializer
// that drives the output register, while the output side pops. The front
// end takes a new item every cycle while its four-entry job queue has room,
// so cells arrive back to back, and a waiting output byte blocks input only
// once the queue is full. Order: the first byte of an item passes through
// the job queue and then the output register before it reaches the ports.
module utf8_encoder_with_color_escapes (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_fore_colour,
    input  logic [7:0]  i_back_colour,
    input  logic [20:0] i_code_point,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  o_out_byte,
    output logic        o_last_byte,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [6:0]  i_cfg_data
);

`include "utf8_encoder_with_color_escapes_defines.svh"

    logic [6:0]   r_fore_offset;
    logic [6:0]   r_back_offset;
    logic         accept;
    ue_pkg::t_job front_job;
    ue_pkg::t_job head_job;
    logic         head_valid;
    logic         head_pop;

    // Configuration: write-only offsets; write them only while no item is
    // in flight.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fore_offset <= ue_pkg::FORE_OFFSET_RESET;
            r_back_offset <= ue_pkg::BACK_OFFSET_RESET;
        end else if (i_cfg_we) begin
            case (ue_pkg::t_cfg_reg'(i_cfg_index))
                ue_pkg::CFG_FORE_OFFSET: r_fore_offset <= i_cfg_data;
                ue_pkg::CFG_BACK_OFFSET: r_back_offset <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Take an item whenever the job queue has a free slot.
    assign accept = push && !full;

    // Front end: compare colours against the kept ones, build the escape
    // runs and the UTF-8 run, and hand the whole job to the queue.
    ue_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_fore_colour (i_fore_colour),
        .i_back_colour (i_back_colour),
        .i_code_point  (i_code_point),
        .i_fore_offset (r_fore_offset),
        .i_back_offset (r_back_offset),
        .o_job         (front_job)
    );

    // Short job queue decouples classification from serialization.
    ue_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_job   (front_job),
        .o_full  (full),
        .i_pop   (head_pop),
        .o_valid (head_valid),
        .o_job   (head_job)
    );

    // Back end: walk the head job byte by byte into the output register,
    // release the job on its last byte.
    ue_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (head_job),
        .i_job_valid (head_valid),
        .o_job_pop   (head_pop),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_out_byte  (o_out_byte),
        .o_last_byte (o_last_byte)
    );

    // A full queue must have a job at its head.
    `UE_ASSERT_NOW(a_full_has_head, full, head_valid, "queue full with no head job")
    // An accepted item leaves the queue non-empty on the next cycle.
    `UE_ASSERT_NEXT(a_accept_fills, accept, head_valid, "accepted item lost from queue")
    // A job is only released while it is at the head.
    `UE_ASSERT_NOW(a_pop_valid, head_pop, head_valid, "job released from empty queue")
    // Reset leaves both sides empty and ready.
    `UE_ASSERT_ALWAYS_NEXT(a_reset_idle, !i_rst_n, empty && !full, "not idle after reset")

endmodule

[sim/tb_utf8_encoder_with_color_escapes.sv]
`timescale 1ns / 1ps
module tb_utf8_encoder_with_color_escapes;
    import ue_pkg::*;

    // Cycles the result side holds off during the back-pressure burst.
    localparam int HOLD_CYCLES  = 300;
    // Cycles with no item moving on either side before the run is abandoned.
    localparam int STALL_LIMIT  = 2000;
    localparam int PHASE_CELLS  = 103;
    localparam int PHASE_COUNT  = 4;

    typedef struct {
        logic [7:0] value;
        logic       ends_cell;
    } term_byte_t;

    // Predicts the terminal byte stream for each cell and matches it
    // against the bytes the block hands out.
    class cell_stream_model;
        logic [6:0] fore_offset;
        logic [6:0] back_offset;
        logic [7:0] kept_fore;
        logic [7:0] kept_back;
        logic [7:0] staged[$];
        term_byte_t pending_bytes[$];
        int         mismatch_count;

        function new();
            fore_offset    = FORE_OFFSET_RESET;
            back_offset    = BACK_OFFSET_RESET;
            kept_fore      = COLOUR_RESET;
            kept_back      = COLOUR_RESET;
            mismatch_count = 0;
        endfunction

        function void set_offset(t_cfg_reg which, logic [6:0] value);
            if (which == CFG_FORE_OFFSET) begin
                fore_offset = value;
            end else begin
                back_offset = value;
            end
        endfunction

        // ESC [ <number> m, number in decimal with no leading zeros.
        function void add_escape(int unsigned num);
            int unsigned hundreds;
            int unsigned tens;
            int unsigned ones;
            hundreds = num / 100;
            tens     = (num / 10) % 10;
            ones     = num % 10;
            staged.push_back(ESC_BYTE);
            staged.push_back(LBRACK_BYTE);
            if (hundreds != 0) begin
                staged.push_back(DIGIT0_BYTE + 8'(hundreds));
            end
            if (hundreds != 0 || tens != 0) begin
                staged.push_back(DIGIT0_BYTE + 8'(tens));
            end
            staged.push_back(DIGIT0_BYTE + 8'(ones));
            staged.push_back(M_BYTE);
        endfunction

        function void take_cell(logic [7:0] fg, logic [7:0] bg, logic [20:0] cp);
            logic [20:0] scalar;
            term_byte_t  entry;
            staged.delete();
            if (fg != kept_fore) begin
                kept_fore = fg;
                add_escape(int'(fore_offset) + int'(fg));
            end
            if (bg != kept_back) begin
                kept_back = bg;
                add_escape(int'(back_offset) + int'(bg));
            end
            scalar = (cp > CP_MAX) ? CP_MAX : cp;
            if (scalar <= CP_1B_MAX) begin
                staged.push_back(scalar[7:0]);
            end else if (scalar < CP_2B_LIMIT) begin
                staged.push_back(LEAD2 | {3'b0, scalar[10:6]});
                staged.push_back(CONT | {2'b0, scalar[5:0]});
            end else if (scalar < CP_3B_LIMIT) begin
                staged.push_back(LEAD3 | {4'b0, scalar[15:12]});
                staged.push_back(CONT | {2'b0, scalar[11:6]});
                staged.push_back(CONT | {2'b0, scalar[5:0]});
            end else begin
                staged.push_back(LEAD4 | {5'b0, scalar[20:18]});
                staged.push_back(CONT | {2'b0, scalar[17:12]});
                staged.push_back(CONT | {2'b0, scalar[11:6]});
                staged.push_back(CONT | {2'b0, scalar[5:0]});
            end
            foreach (staged[i]) begin
                entry.value     = staged[i];
                entry.ends_cell = (i == staged.size() - 1);
                pending_bytes.push_back(entry);
            end
        endfunction

        function void match_byte(logic [7:0] got_byte, logic got_last);
            term_byte_t want;
            if (pending_bytes.size() == 0) begin
                $error("out_byte: no byte expected, got 0x%02h (last_byte %0b)",
                       got_byte, got_last);
                mismatch_count++;
                return;
            end
            want = pending_bytes.pop_front();
            if (got_byte !== want.value) begin
                $error("out_byte: expected 0x%02h, got 0x%02h", want.value, got_byte);
                mismatch_count++;
            end
            if (got_last !== want.ends_cell) begin
                $error("last_byte: expected %0b, got %0b", want.ends_cell, got_last);
                mismatch_count++;
            end
        endfunction

        function int pending_count();
            return pending_bytes.size();
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        push;
    logic        full;
    logic [7:0]  i_fore_colour;
    logic [7:0]  i_back_colour;
    logic [20:0] i_code_point;
    logic        empty;
    logic        pop;
    logic [7:0]  o_out_byte;
    logic        o_last_byte;
    logic        i_cfg_we;
    logic        i_cfg_index;
    logic [6:0]  i_cfg_data;

    cell_stream_model model = new();

    // Hand-off flags between the cell source and the byte sink.
    bit hold_request  = 1'b0;
    bit sender_steady = 1'b0;
    bit calm_tail     = 1'b0;

    utf8_encoder_with_color_escapes dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_fore_colour (i_fore_colour),
        .i_back_colour (i_back_colour),
        .i_code_point  (i_code_point),
        .empty         (empty),
        .pop           (pop),
        .o_out_byte    (o_out_byte),
        .o_last_byte   (o_last_byte),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Offer one cell and hold it until the block takes it; the prediction is
    // made at the accepting edge. Push stays high so the next cell can follow
    // back to back, unless a random idle burst drops it.
    task automatic send_cell(input logic [7:0] fg, input logic [7:0] bg,
                             input logic [20:0] cp);
        push          <= 1'b1;
        i_fore_colour <= fg;
        i_back_colour <= bg;
        i_code_point  <= cp;
        do @(posedge i_clk); while (full);
        model.take_cell(fg, bg, cp);
        if (!sender_steady && $urandom_range(0, 7) == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
    endtask

    // Stop offering cells and wait for every predicted byte to come out, then
    // let the pipeline idle before touching the registers.
    task automatic drain_results();
        push <= 1'b0;
        do @(posedge i_clk); while (model.pending_count() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_offset(input t_cfg_reg which, input logic [6:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= which;
        i_cfg_data  <= value;
        @(posedge i_clk);
        model.set_offset(which, value);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Favor repeats of the kept colour (no escape), small palettes and the
    // reset colour; the full byte range keeps every bit moving.
    function automatic logic [7:0] pick_colour(input logic [7:0] kept);
        case ($urandom_range(0, 3))
            0:       return kept;
            1:       return 8'($urandom_range(0, 15));
            2:       return COLOUR_RESET;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic send_random_cell();
        logic [7:0]  fg;
        logic [7:0]  bg;
        logic [20:0] cp;
        fg = pick_colour(model.kept_fore);
        bg = pick_colour(model.kept_back);
        case ($urandom_range(0, 9))
            0, 1, 2: cp = 21'($urandom_range(0, 'h7F));
            3, 4:    cp = 21'($urandom_range('h80, 'h7FF));
            5:       cp = 21'($urandom_range('h800, 'hFFFF));
            6:       cp = 21'($urandom_range('hD800, 'hDFFF));
            7:       cp = 21'($urandom_range('h10000, 'h10FFFF));
            8:       cp = 21'($urandom_range('h110000, 'h1FFFFF));
            default: cp = 21'($urandom());
        endcase
        send_cell(fg, bg, cp);
    endtask

    // Byte sink: match each accepted byte, then decide whether to pop next
    // cycle. Short random stalls, one long hold on request, and none once the
    // calm tail starts.
    initial begin : byte_sink
        int unsigned stall_left;
        stall_left = 0;
        pop <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && pop && !empty) begin
                model.match_byte(o_out_byte, o_last_byte);
            end
            if (!i_rst_n) begin
                pop <= 1'b0;
            end else if (stall_left != 0) begin
                pop <= 1'b0;
                stall_left--;
            end else if (hold_request) begin
                hold_request = 1'b0;
                pop <= 1'b0;
                stall_left = HOLD_CYCLES - 1;
            end else if (!calm_tail && $urandom_range(0, 9) == 0) begin
                pop <= 1'b0;
                stall_left = $urandom_range(1, 19) - 1;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    // Abandon the run if neither side moves an item for too long.
    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((push && !full) || (pop && !empty)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= STALL_LIMIT) begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    initial begin : cell_source
        int phase;
        int k;
        push          <= 1'b0;
        i_fore_colour <= '0;
        i_back_colour <= '0;
        i_code_point  <= '0;
        i_cfg_we      <= 1'b0;
        i_cfg_index   <= CFG_FORE_OFFSET;
        i_cfg_data    <= '0;
        i_rst_n       <= 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed cells at the reset offsets.
        send_cell(8'd255, 8'd255, 21'h41);       // reset colour: no escape at all
        send_cell(8'd0, 8'd0, 21'h0);            // both escapes, code point zero
        send_cell(8'd0, 8'd0, 21'h7F);           // top of one-byte range
        send_cell(8'd7, 8'd0, 21'h80);           // foreground only, two bytes
        send_cell(8'd7, 8'd7, 21'h7FF);          // background only
        send_cell(8'd255, 8'd255, 21'h800);      // three-digit numbers, three bytes
        send_cell(8'd255, 8'd255, 21'hD800);     // surrogates encode as usual
        send_cell(8'd1, 8'd2, 21'hDFFF);
        send_cell(8'd1, 8'd2, 21'hFFFF);
        send_cell(8'd1, 8'd2, 21'h10000);        // four bytes
        send_cell(8'd200, 8'd100, 21'h10FFFF);
        send_cell(8'd201, 8'd101, 21'h110000);   // clamp just above the top
        send_cell(8'd202, 8'd102, 21'h1FFFFF);   // clamp from all ones
        send_cell(8'hAA, 8'h55, 21'h0AAAAA);
        send_cell(8'h55, 8'hAA, 21'h155555);

        // Zero offsets: number zero prints as a lone digit, then one and two
        // digit numbers.
        drain_results();
        write_offset(CFG_FORE_OFFSET, 7'd0);
        write_offset(CFG_BACK_OFFSET, 7'd0);
        send_cell(8'd0, 8'd0, 21'h78);
        send_cell(8'd9, 8'd9, 21'h41);
        send_cell(8'd10, 8'd10, 21'h42);

        // Largest offsets: numbers 382 and 127.
        drain_results();
        write_offset(CFG_FORE_OFFSET, 7'd127);
        write_offset(CFG_BACK_OFFSET, 7'd127);
        send_cell(8'd255, 8'd255, 21'h7E);
        send_cell(8'd0, 8'd0, 21'h20);

        // Random phases, each behind a full drain and a fresh pair of offsets.
        for (phase = 0; phase < PHASE_COUNT; phase++) begin
            drain_results();
            case (phase)
                0: begin
                    write_offset(CFG_FORE_OFFSET, FORE_OFFSET_RESET);
                    write_offset(CFG_BACK_OFFSET, BACK_OFFSET_RESET);
                end
                2: begin
                    write_offset(CFG_FORE_OFFSET, 7'd127);
                    write_offset(CFG_BACK_OFFSET, 7'd0);
                end
                default: begin
                    write_offset(CFG_FORE_OFFSET, 7'($urandom_range(0, 127)));
                    write_offset(CFG_BACK_OFFSET, 7'($urandom_range(0, 127)));
                end
            endcase
            for (k = 0; k < PHASE_CELLS; k++) begin
                // Hold the sink off while cells keep coming so the job queue
                // fills and the block pushes back on its input.
                if (phase == 1 && k == 0) begin
                    sender_steady = 1'b1;
                    hold_request  = 1'b1;
                end
                if (phase == 1 && k == 40) begin
                    sender_steady = 1'b0;
                end
                // Finish with no idling on either side.
                if (phase == PHASE_COUNT - 1 && k == PHASE_CELLS - 45) begin
                    sender_steady = 1'b1;
                    calm_tail     = 1'b1;
                end
                send_random_cell();
            end
        end

        drain_results();
        repeat (8) @(posedge i_clk);
        if (model.mismatch_count == 0 && model.pending_count() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
